[sv/pitch_to_note_cents_defines.svh]
// Assertion macros used by the pitch_to_note_cents checker file.
// No dependencies; include by bare file name.
`ifndef PITCH_TO_NOTE_CENTS_DEFINES_SVH
`define PITCH_TO_NOTE_CENTS_DEFINES_SVH

// Check a property on the rising clock edge, disabled while reset is high
`define PTNC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on the rising clock edge, reset included
`define PTNC_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ptnc_pkg.sv]
// Shared types, constants and the log2 table generator for pitch_to_note_cents.
// No dependencies; other files refer to it by scoped names.
package ptnc_pkg;

   // Field widths
   localparam int FREQ_W     = 20;
   localparam int MODE_W     = 2;
   localparam int TRIM_W     = 13;
   localparam int FLAT_W     = 3;
   localparam int NOTE_OUT_W = 8;
   localparam int CENTS_W    = 10;
   localparam int TCENTS_W   = 18;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_ADDR_W-1:0] REG_TUNING_MODE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PITCH_432      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_REFERENCE_TRIM = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_FLAT_SEMITONES = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_FREQUENCY  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_FREQUENCY  = 3'd5;

   // Tuning modes
   localparam logic [MODE_W-1:0] MODE_CHROMATIC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GUITAR    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BASS      = 2'd2;

   // Reset values
   localparam logic [MODE_W-1:0] RST_TUNING_MODE    = MODE_CHROMATIC;
   localparam logic [TRIM_W-1:0] RST_REFERENCE_TRIM = 13'd7040;
   localparam logic [FLAT_W-1:0] RST_FLAT_SEMITONES = 3'd0;
   localparam logic [FREQ_W-1:0] RST_MIN_FREQUENCY  = 20'd320;
   localparam logic [FREQ_W-1:0] RST_MAX_FREQUENCY  = 20'd32000;

   // Reference ranges in 1/16 Hz
   localparam logic [TRIM_W-1:0] REF432_LO = 13'd6848;
   localparam logic [TRIM_W-1:0] REF432_HI = 13'd6992;
   localparam logic [TRIM_W-1:0] REF440_LO = 13'd6976;
   localparam logic [TRIM_W-1:0] REF440_HI = 13'd7120;

   localparam logic [FLAT_W-1:0] FLAT_MAX = 3'd6;

   // Input frequency fraction bits; the reference always has four
   localparam int FREQ_FRAC_BITS = 4;

   // Log2 arithmetic
   localparam int MANT_FRAC = 30;
   localparam int LOG_FRAC  = 24;
   localparam int EXP_W     = 5;
   localparam int LOG_W     = EXP_W + LOG_FRAC;
   localparam int LEVEL_W   = LOG_W + 2;
   localparam int FRAC_ADJ  = (FREQ_FRAC_BITS - 4) * (2 ** LOG_FRAC);

   // Pitch in tenths of a cent and the note split
   localparam int PITCH_W     = 20;
   localparam int SEMI_TENTHS = 1000;
   localparam int PITCH_BASE  = 69000;
   localparam int SCALE       = 12000;
   localparam int NOTE_BIAS   = 300;
   localparam int DIV_BIAS    = NOTE_BIAS * SEMI_TENTHS + SEMI_TENTHS / 2;
   localparam int DIV_X_W     = 19;
   localparam int RECIP_SHIFT = 29;
   localparam int RECIP       = (2 ** RECIP_SHIFT + SEMI_TENTHS - 1) / SEMI_TENTHS;
   localparam int QUOT_W      = 9;
   localparam int NOTE_W      = 10;
   localparam int NOTE_MAX    = 150;
   localparam int TARGET_CENTS_MAX = 130000;

   // Open strings
   localparam int GUITAR_N = 6;
   localparam int BASS_N   = 4;
   localparam logic [NOTE_OUT_W-1:0] GUITAR_STRINGS [GUITAR_N] =
      '{8'd40, 8'd45, 8'd50, 8'd55, 8'd59, 8'd64};
   localparam logic [NOTE_OUT_W-1:0] BASS_STRINGS [BASS_N] =
      '{8'd28, 8'd33, 8'd38, 8'd43};

   // Pipeline depth: log2 unit, level stage, note unit
   localparam int LOG_STAGES  = 4;
   localparam int NOTE_STAGES = 5;
   localparam int NUM_STAGES  = LOG_STAGES + 1 + NOTE_STAGES;

   // Tuning settings handed to the note unit
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [FLAT_W-1:0] flat;
   } tune_cfg_type;

   // Table entry log2(1 + idx/2^tbits) in Q1.24, by square-and-compare
   function automatic logic [LOG_FRAC:0] log_entry(input int unsigned tbits,
                                                   input int unsigned idx);
      logic [63:0] one;
      logic [63:0] x;
      logic [63:0] r;
      one = 64'd1 << MANT_FRAC;
      x   = one;
      r   = '0;
      if (64'(idx) >= (64'd1 << tbits)) begin
         r = 64'd1 << LOG_FRAC;
      end else begin
         x = one + (64'(idx) << (MANT_FRAC - tbits));
         for (int k = 0; k < LOG_FRAC; k++) begin
            x = (x * x) >> MANT_FRAC;
            r = r << 1;
            if (x >= (one << 1)) begin
               x = x >> 1;
               r = r | 64'd1;
            end
         end
      end
      return r[LOG_FRAC:0];
   endfunction

endpackage

[sv/ptnc_log2.sv]
// Four-stage fixed-point log2 of a nonzero 20-bit value, result in Q5.24.
// Depends on ptnc_pkg (widths, table generator).
module ptnc_log2 #(
   parameter int TBL_BITS = 8
) (
   input  logic                                   clock,
   input  logic [ptnc_pkg::LOG_STAGES-1:0]        stage_en,
   input  logic [ptnc_pkg::FREQ_W-1:0]            value_i,
   output logic [ptnc_pkg::LOG_W-1:0]             log_o
);

   localparam int FreqW    = ptnc_pkg::FREQ_W;
   localparam int ExpW     = ptnc_pkg::EXP_W;
   localparam int FracW    = ptnc_pkg::LOG_FRAC;
   localparam int LogW     = ptnc_pkg::LOG_W;
   localparam int TblDepth = 2 ** TBL_BITS + 1;
   localparam int IdxW     = TBL_BITS + 1;
   localparam int NloW     = FreqW - 1 - TBL_BITS;
   localparam int ProdW    = FracW + 1 + NloW;

   // Constant table of log2(1 + i/2^TBL_BITS), one extra entry for 1.0
   logic [FracW:0] rom_tbl [TblDepth];
   for (genvar gi = 0; gi < TblDepth; gi++) begin : g_rom
      localparam logic [FracW:0] Entry = ptnc_pkg::log_entry(TBL_BITS, gi);
      assign rom_tbl[gi] = Entry;
   end

   // Stage 0: find the leading one and normalize
   logic [ExpW-1:0]     lead;
   logic [FreqW-1:0]    norm;
   logic [ExpW-1:0]     e_s0_ff;
   logic [TBL_BITS-1:0] idx_s0_ff;
   logic [NloW-1:0]     nlo_s0_ff;

   always_comb begin
      lead = '0;
      for (int i = 0; i < FreqW; i++) begin
         if (value_i[i]) lead = ExpW'(i);
      end
   end

   assign norm = value_i << (ExpW'(FreqW - 1) - lead);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         e_s0_ff   <= lead;
         idx_s0_ff <= norm[FreqW-2 -: TBL_BITS];
         nlo_s0_ff <= norm[NloW-1:0];
      end
   end

   // Stage 1: read both neighbors and take the slope
   logic [IdxW-1:0]  idx_lo;
   logic [IdxW-1:0]  idx_hi;
   logic [FracW:0]   a_s1_ff;
   logic [FracW:0]   d_s1_ff;
   logic [ExpW-1:0]  e_s1_ff;
   logic [NloW-1:0]  nlo_s1_ff;

   assign idx_lo = IdxW'(idx_s0_ff);
   assign idx_hi = idx_lo + IdxW'(1);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         a_s1_ff   <= rom_tbl[idx_lo];
         d_s1_ff   <= rom_tbl[idx_hi] - rom_tbl[idx_lo];
         e_s1_ff   <= e_s0_ff;
         nlo_s1_ff <= nlo_s0_ff;
      end
   end

   // Stage 2: interpolate between the two entries, truncated
   logic [ProdW-1:0] interp_prod;
   logic [FracW:0]   interp_s2_ff;
   logic [FracW:0]   a_s2_ff;
   logic [ExpW-1:0]  e_s2_ff;

   assign interp_prod = ProdW'(d_s1_ff) * ProdW'(nlo_s1_ff);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         interp_s2_ff <= interp_prod[NloW +: (FracW + 1)];
         a_s2_ff      <= a_s1_ff;
         e_s2_ff      <= e_s1_ff;
      end
   end

   // Stage 3: add exponent, table value and interpolation
   logic [LogW-1:0] log_in;
   logic [LogW-1:0] log_ff;

   assign log_in = LogW'({e_s2_ff, {FracW{1'b0}}}) + LogW'(a_s2_ff) + LogW'(interp_s2_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         log_ff <= log_in;
      end
   end

   assign log_o = log_ff;

endmodule

[sv/ptnc_note.sv]
// Five-stage note unit: scales the log ratio to tenths of a cent, splits
// it into note and cents, snaps to open strings. Depends on ptnc_pkg.
module ptnc_note (
   input  logic                                   clock,
   input  logic [ptnc_pkg::NOTE_STAGES-1:0]       stage_en,
   input  logic [ptnc_pkg::LEVEL_W-1:0]           level_i,
   input  ptnc_pkg::tune_cfg_type                 tune_cfg,
   input  logic                                   reading_ok,
   output logic [ptnc_pkg::NOTE_OUT_W-1:0]        note_number,
   output logic [ptnc_pkg::CENTS_W-1:0]           cents_from_note,
   output logic [ptnc_pkg::NOTE_OUT_W-1:0]        target_note,
   output logic [ptnc_pkg::TCENTS_W-1:0]          cents_from_target
);

   localparam int LevelW  = ptnc_pkg::LEVEL_W;
   localparam int ProdW   = LevelW + 15;
   localparam int PitchW  = ptnc_pkg::PITCH_W;
   localparam int SumW    = PitchW + 1;
   localparam int XW      = ptnc_pkg::DIV_X_W;
   localparam int QW      = ptnc_pkg::QUOT_W;
   localparam int QProdW  = XW + 20;
   localparam int NoteW   = ptnc_pkg::NOTE_W;
   localparam int OutW    = ptnc_pkg::NOTE_OUT_W;
   localparam int CentsW  = ptnc_pkg::CENTS_W;
   localparam int TcW     = ptnc_pkg::TCENTS_W;
   localparam int DistW   = NoteW + 1;

   // Distance from a note to an open string
   function automatic logic [DistW-1:0] string_dist(input logic [NoteW-1:0] note,
                                                    input logic [OutW-1:0]  str);
      logic [DistW-1:0] diff;
      diff = {note[NoteW-1], note} - DistW'(str);
      return diff[DistW-1] ? (~diff + DistW'(1)) : diff;
   endfunction

   // Stage 5: scale the log ratio by 12000
   logic signed [ProdW-1:0] level_ext;
   logic signed [ProdW-1:0] scale_ext;
   logic signed [ProdW-1:0] prod_ff;

   assign level_ext = ProdW'($signed(level_i));
   assign scale_ext = ProdW'(ptnc_pkg::SCALE);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= level_ext * scale_ext;
      end
   end

   // Stage 6: round to tenths of a cent, add base and flat offset
   logic signed [ProdW-1:0] rnd_sum;
   logic signed [ProdW-1:0] rnd_shift;
   logic [SumW-1:0]         pitch_in;
   logic [SumW-1:0]         biased;
   logic [PitchW-1:0]       pitch_s6_ff;
   logic [XW-1:0]           x_s6_ff;

   assign rnd_sum   = prod_ff + ProdW'(2 ** (ptnc_pkg::LOG_FRAC - 1));
   assign rnd_shift = rnd_sum >>> ptnc_pkg::LOG_FRAC;
   assign pitch_in  = SumW'(rnd_shift) + SumW'(ptnc_pkg::PITCH_BASE)
                    + SumW'(tune_cfg.flat) * SumW'(ptnc_pkg::SEMI_TENTHS);
   assign biased    = pitch_in + SumW'(ptnc_pkg::DIV_BIAS);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         pitch_s6_ff <= pitch_in[PitchW-1:0];
         x_s6_ff     <= biased[XW-1:0];
      end
   end

   // Stage 7: divide the biased pitch by 1000 through its reciprocal
   logic [QProdW-1:0] qprod;
   logic [QW-1:0]     q_s7_ff;
   logic [XW-1:0]     x_s7_ff;
   logic [PitchW-1:0] pitch_s7_ff;

   assign qprod = QProdW'(x_s6_ff) * QProdW'(ptnc_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         q_s7_ff     <= qprod[ptnc_pkg::RECIP_SHIFT +: QW];
         x_s7_ff     <= x_s6_ff;
         pitch_s7_ff <= pitch_s6_ff;
      end
   end

   // Stage 8: note, cents, saturated note and string snap
   logic [XW-1:0]      rem_full;
   logic [CentsW-1:0]  cents_in;
   logic [NoteW-1:0]   note_raw;
   logic [OutW-1:0]    note_sat;
   logic [OutW-1:0]    guitar_pick;
   logic [DistW-1:0]   guitar_dist;
   logic [OutW-1:0]    bass_pick;
   logic [DistW-1:0]   bass_dist;
   logic [OutW-1:0]    target_in;
   logic [OutW-1:0]    note_s8_ff;
   logic [CentsW-1:0]  cents_s8_ff;
   logic [OutW-1:0]    target_s8_ff;
   logic [PitchW-1:0]  pitch_s8_ff;
   logic               ok_s8_ff;

   assign rem_full = x_s7_ff - XW'(q_s7_ff) * XW'(ptnc_pkg::SEMI_TENTHS);
   assign cents_in = CentsW'(rem_full) - CentsW'(ptnc_pkg::SEMI_TENTHS / 2);
   assign note_raw = NoteW'(q_s7_ff) - NoteW'(ptnc_pkg::NOTE_BIAS);

   // Clamp the note into 0..150
   always_comb begin
      if ($signed(note_raw) < 0) begin
         note_sat = '0;
      end else if ($signed(note_raw) > NoteW'(ptnc_pkg::NOTE_MAX)) begin
         note_sat = OutW'(ptnc_pkg::NOTE_MAX);
      end else begin
         note_sat = note_raw[OutW-1:0];
      end
   end

   // Pick the nearest string, the lowest one on a tie
   always_comb begin
      guitar_pick = ptnc_pkg::GUITAR_STRINGS[0];
      guitar_dist = string_dist(note_raw, ptnc_pkg::GUITAR_STRINGS[0]);
      for (int i = 1; i < ptnc_pkg::GUITAR_N; i++) begin
         if (string_dist(note_raw, ptnc_pkg::GUITAR_STRINGS[i]) < guitar_dist) begin
            guitar_pick = ptnc_pkg::GUITAR_STRINGS[i];
            guitar_dist = string_dist(note_raw, ptnc_pkg::GUITAR_STRINGS[i]);
         end
      end
   end

   always_comb begin
      bass_pick = ptnc_pkg::BASS_STRINGS[0];
      bass_dist = string_dist(note_raw, ptnc_pkg::BASS_STRINGS[0]);
      for (int i = 1; i < ptnc_pkg::BASS_N; i++) begin
         if (string_dist(note_raw, ptnc_pkg::BASS_STRINGS[i]) < bass_dist) begin
            bass_pick = ptnc_pkg::BASS_STRINGS[i];
            bass_dist = string_dist(note_raw, ptnc_pkg::BASS_STRINGS[i]);
         end
      end
   end

   always_comb begin
      unique case (tune_cfg.mode)
         ptnc_pkg::MODE_GUITAR: target_in = guitar_pick;
         ptnc_pkg::MODE_BASS:   target_in = bass_pick;
         default:               target_in = note_sat;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         note_s8_ff   <= note_sat;
         cents_s8_ff  <= cents_in;
         target_s8_ff <= target_in;
         pitch_s8_ff  <= pitch_s7_ff;
         ok_s8_ff     <= reading_ok;
      end
   end

   // Stage 9: cents from target, saturated; zero the fields of a bad reading
   logic [SumW-1:0]  tc_diff;
   logic [TcW-1:0]   tc_sat;
   logic [OutW-1:0]  note_ff;
   logic [CentsW-1:0] cents_ff;
   logic [OutW-1:0]  target_ff;
   logic [TcW-1:0]   tcents_ff;

   assign tc_diff = {pitch_s8_ff[PitchW-1], pitch_s8_ff}
                  - SumW'(target_s8_ff) * SumW'(ptnc_pkg::SEMI_TENTHS);

   always_comb begin
      if ($signed(tc_diff) > $signed(SumW'(ptnc_pkg::TARGET_CENTS_MAX))) begin
         tc_sat = TcW'(ptnc_pkg::TARGET_CENTS_MAX);
      end else if ($signed(tc_diff) < $signed(SumW'(-ptnc_pkg::TARGET_CENTS_MAX))) begin
         tc_sat = TcW'(-ptnc_pkg::TARGET_CENTS_MAX);
      end else begin
         tc_sat = tc_diff[TcW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         note_ff   <= ok_s8_ff ? note_s8_ff   : '0;
         cents_ff  <= ok_s8_ff ? cents_s8_ff  : '0;
         target_ff <= ok_s8_ff ? target_s8_ff : '0;
         tcents_ff <= ok_s8_ff ? tc_sat       : '0;
      end
   end

   assign note_number       = note_ff;
   assign cents_from_note   = cents_ff;
   assign target_note       = target_ff;
   assign cents_from_target = tcents_ff;

endmodule

[sv/pitch_to_note_cents.sv]
// pitch_to_note_cents: turns a Q16.4 Hz frequency into the nearest MIDI note,
// its offset in tenths of a cent, and a tuning target (chromatic note or the
// nearest open guitar or bass string) with its own offset. The block is a
// ten-stage pipeline: four stages of table-based log2 (run on the input and,
// in parallel, on the clamped reference), one stage for the log ratio, and
// five stages for scaling, the split into note and cents, string snap and
// output. One item is accepted every cycle unless rsp_tready stalls the
// output; a stall backs up through the stage valid bits without losing or
// repeating an item. Frequencies outside the inclusive min/max window give
// a result with rsp_tuser low and all fields but the echoed frequency at
// zero. Configuration writes take effect at once and belong only between
// items.
// Depends on ptnc_pkg, ptnc_log2 and ptnc_note.
module pitch_to_note_cents #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] frequency, [23:20] zero
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] note_number, [17:8] cents_from_note,
                                    // [25:18] target_note, [43:26] cents_from_target,
                                    // [63:44] frequency_echo
   output logic        rsp_tuser,   // [0] reading_valid
   // Configuration writes
   input  logic                                  csr_we,
   input  logic [ptnc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [ptnc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int FreqW    = ptnc_pkg::FREQ_W;
   localparam int TrimW    = ptnc_pkg::TRIM_W;
   localparam int LogW     = ptnc_pkg::LOG_W;
   localparam int LevelW   = ptnc_pkg::LEVEL_W;
   localparam int NStages  = ptnc_pkg::NUM_STAGES;
   localparam int LogSt    = ptnc_pkg::LOG_STAGES;
   localparam int NoteSt   = ptnc_pkg::NOTE_STAGES;

   // Configuration registers
   logic [ptnc_pkg::MODE_W-1:0] tuning_mode_ff;
   logic                        pitch_432_ff;
   logic [TrimW-1:0]            reference_trim_ff;
   logic [ptnc_pkg::FLAT_W-1:0] flat_semitones_ff;
   logic [FreqW-1:0]            min_frequency_ff;
   logic [FreqW-1:0]            max_frequency_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_mode_ff    <= ptnc_pkg::RST_TUNING_MODE;
         pitch_432_ff      <= 1'b0;
         reference_trim_ff <= ptnc_pkg::RST_REFERENCE_TRIM;
         flat_semitones_ff <= ptnc_pkg::RST_FLAT_SEMITONES;
         min_frequency_ff  <= ptnc_pkg::RST_MIN_FREQUENCY;
         max_frequency_ff  <= ptnc_pkg::RST_MAX_FREQUENCY;
      end else if (csr_we) begin
         unique case (csr_addr)
            ptnc_pkg::REG_TUNING_MODE:    tuning_mode_ff    <= csr_wdata[ptnc_pkg::MODE_W-1:0];
            ptnc_pkg::REG_PITCH_432:      pitch_432_ff      <= csr_wdata[0];
            ptnc_pkg::REG_REFERENCE_TRIM: reference_trim_ff <= csr_wdata[TrimW-1:0];
            ptnc_pkg::REG_FLAT_SEMITONES: flat_semitones_ff <= csr_wdata[ptnc_pkg::FLAT_W-1:0];
            ptnc_pkg::REG_MIN_FREQUENCY:  min_frequency_ff  <= csr_wdata[FreqW-1:0];
            ptnc_pkg::REG_MAX_FREQUENCY:  max_frequency_ff  <= csr_wdata[FreqW-1:0];
            default: ;
         endcase
      end
   end

   // Saturate mode and flat offset, clamp the reference into its range
   ptnc_pkg::tune_cfg_type tune_cfg;
   logic [TrimW-1:0]       ref_lo;
   logic [TrimW-1:0]       ref_hi;
   logic [TrimW-1:0]       ref_clamped;

   assign tune_cfg.mode = (tuning_mode_ff > ptnc_pkg::MODE_BASS) ? ptnc_pkg::MODE_BASS
                                                                  : tuning_mode_ff;
   assign tune_cfg.flat = (flat_semitones_ff > ptnc_pkg::FLAT_MAX) ? ptnc_pkg::FLAT_MAX
                                                                    : flat_semitones_ff;
   assign ref_lo = pitch_432_ff ? ptnc_pkg::REF432_LO : ptnc_pkg::REF440_LO;
   assign ref_hi = pitch_432_ff ? ptnc_pkg::REF432_HI : ptnc_pkg::REF440_HI;

   always_comb begin
      if (reference_trim_ff < ref_lo) begin
         ref_clamped = ref_lo;
      end else if (reference_trim_ff > ref_hi) begin
         ref_clamped = ref_hi;
      end else begin
         ref_clamped = reference_trim_ff;
      end
   end

   // Stage control: a stage loads when it is empty or its successor loads
   logic [NStages-1:0] valid_ff;
   logic [NStages-1:0] stage_ready;

   always_comb begin
      stage_ready[NStages-1] = !valid_ff[NStages-1] || rsp_tready;
      for (int k = NStages - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_ready[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NStages; k++) begin
            if (stage_ready[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   assign req_tready = stage_ready[0];

   // Window check and echo travel beside the data
   logic [FreqW-1:0] freq;
   logic [FreqW-1:0] freq_nz;
   logic             win_in;
   logic             win_ff  [NStages];
   logic [FreqW-1:0] echo_ff [NStages];

   assign freq    = req_tdata[FreqW-1:0];
   assign freq_nz = (freq == '0) ? FreqW'(1) : freq;
   assign win_in  = (freq >= min_frequency_ff) && (freq <= max_frequency_ff);

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         win_ff[0]  <= win_in;
         echo_ff[0] <= freq;
      end
      for (int k = 1; k < NStages; k++) begin
         if (stage_ready[k]) begin
            win_ff[k]  <= win_ff[k-1];
            echo_ff[k] <= echo_ff[k-1];
         end
      end
   end

   // Log2 of the frequency and of the reference, side by side
   logic [LogW-1:0] log_freq;
   logic [LogW-1:0] log_ref;

   ptnc_log2 #(
      .TBL_BITS (LOG_TABLE_BITS)
   ) u_log_freq (
      .clock    (clock),
      .stage_en (stage_ready[LogSt-1:0]),
      .value_i  (freq_nz),
      .log_o    (log_freq)
   );

   ptnc_log2 #(
      .TBL_BITS (LOG_TABLE_BITS)
   ) u_log_ref (
      .clock    (clock),
      .stage_en (stage_ready[LogSt-1:0]),
      .value_i  (FreqW'(ref_clamped)),
      .log_o    (log_ref)
   );

   // Level stage: log2 of the frequency ratio
   logic [LevelW-1:0] level_in;
   logic [LevelW-1:0] level_ff;

   assign level_in = LevelW'(log_freq) - LevelW'(log_ref) - LevelW'(ptnc_pkg::FRAC_ADJ);

   always_ff @(posedge clock) begin
      if (stage_ready[LogSt]) begin
         level_ff <= level_in;
      end
   end

   // Note, cents and target; the window flag of stage 7 enters stage 8 with its data
   logic [ptnc_pkg::NOTE_OUT_W-1:0] note_number;
   logic [ptnc_pkg::CENTS_W-1:0]    cents_from_note;
   logic [ptnc_pkg::NOTE_OUT_W-1:0] target_note;
   logic [ptnc_pkg::TCENTS_W-1:0]   cents_from_target;

   ptnc_note u_note (
      .clock             (clock),
      .stage_en          (stage_ready[NStages-1 -: NoteSt]),
      .level_i           (level_ff),
      .tune_cfg          (tune_cfg),
      .reading_ok        (win_ff[NStages-3]),
      .note_number       (note_number),
      .cents_from_note   (cents_from_note),
      .target_note       (target_note),
      .cents_from_target (cents_from_target)
   );

   // Drive the response channel from the last stage
   assign rsp_tvalid = valid_ff[NStages-1];
   assign rsp_tuser  = win_ff[NStages-1];
   assign rsp_tdata  = {echo_ff[NStages-1], cents_from_target, target_note,
                        cents_from_note, note_number};

endmodule

[sv/ptnc_checker.sv]
// Port-level checks for pitch_to_note_cents, bound to the top level.
// Depends on pitch_to_note_cents_defines.svh.
`include "pitch_to_note_cents_defines.svh"

module ptnc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);

   // Hold a stalled result
   `PTNC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Show nothing right after reset
   `PTNC_ASSERT_RST(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result shown after reset")

   // Zero every field but the echo of an out-of-window reading
   `PTNC_ASSERT(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[43:0] == 44'd0, "invalid reading with nonzero fields")

   // Keep cents and note of a valid reading in range
   `PTNC_ASSERT(a_valid_range, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[7:0] <= 8'd150 && $signed(rsp_tdata[17:8]) >= -10'sd500 && $signed(rsp_tdata[17:8]) <= 10'sd499, "note or cents out of range")

endmodule

bind pitch_to_note_cents ptnc_checker u_ptnc_checker (.*);
